// ===== design/mexp_pkg.sv =====
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared widths, constants and controller/datapath interface types for the
// modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

    // field widths of the item and result
    localparam int BASE_WIDTH     = 31;
    localparam int EXPONENT_WIDTH = 32;
    localparam int POWER_WIDTH    = 31;
    localparam int MODULUS_WIDTH  = 31;

    // multiplier pass walks every bit of the widest first operand
    localparam int MUL_STEPS = BASE_WIDTH;
    localparam int CNT_WIDTH = $clog2(MUL_STEPS);

    // modulus after reset
    localparam logic [MODULUS_WIDTH-1:0] MODULUS_RESET = 31'd1000000007;

    // which product the shared modular multiplier forms
    typedef enum logic [1:0] {
        MUL_REDUCE = 2'd0,  // base * 1, reduces the raw base
        MUL_ACC    = 2'd1,  // accumulator * base
        MUL_SQR    = 2'd2   // base * base
    } mul_op_t;

    // controller to datapath
    typedef struct packed {
        logic    load;       // capture a new item, accumulator to one
        logic    mul_start;  // launch a multiplier pass
        mul_op_t mul_op;
        logic    exp_shift;  // drop the exponent's low bit
        logic    out_load;   // move the result into the output register
    } mexp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic mod_small;  // modulus below two
        logic exp_zero;
        logic exp_lsb;
        logic exp_last;   // no set bits above the low bit
        logic mul_done;   // multiplier pass written back
        logic out_busy;   // output register full and not taken this cycle
    } mexp_sts_t;

endpackage

// ===== design/mexp_ctrl.sv =====
// ----------------------------------------------------------------------------
// mexp_ctrl
// Sequencer for right-to-left square-and-multiply: reduces the base, then per
// exponent bit launches an optional multiply and a square on the datapath.
// ----------------------------------------------------------------------------
module mexp_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mexp_pkg::mexp_sts_t sts,
    output mexp_pkg::mexp_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_RED_WAIT,
        ST_STEP,
        ST_ACC_WAIT,
        ST_SQR_WAIT,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state and commands
    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.mul_op    = mexp_pkg::MUL_REDUCE;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                if (sts.mod_small || sts.exp_zero) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = mexp_pkg::MUL_REDUCE;
                    state_next    = ST_RED_WAIT;
                end
            end
            ST_RED_WAIT: begin
                if (sts.mul_done) begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                if (sts.exp_zero) begin
                    state_next = ST_FINISH;
                end else if (sts.exp_lsb) begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = mexp_pkg::MUL_ACC;
                    state_next    = ST_ACC_WAIT;
                end else begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = mexp_pkg::MUL_SQR;
                    state_next    = ST_SQR_WAIT;
                end
            end
            ST_ACC_WAIT: begin
                if (sts.mul_done) begin
                    if (sts.exp_last) begin
                        // last set bit: the final square is never used
                        state_next = ST_FINISH;
                    end else begin
                        cmd.mul_start = 1'b1;
                        cmd.mul_op    = mexp_pkg::MUL_SQR;
                        state_next    = ST_SQR_WAIT;
                    end
                end
            end
            ST_SQR_WAIT: begin
                if (sts.mul_done) begin
                    cmd.exp_shift = 1'b1;
                    state_next    = ST_STEP;
                end
            end
            ST_FINISH: begin
                if (!sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/mexp_datapath.sv =====
// ----------------------------------------------------------------------------
// mexp_datapath
// Operand registers, modulus register, shared bit-serial modular multiplier
// (shift-add with two conditional subtracts per step) and output register.
// ----------------------------------------------------------------------------
module mexp_datapath #(
    parameter int EXP_BITS = 32,
    parameter int MOD_BITS = 31
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [mexp_pkg::MODULUS_WIDTH-1:0]    cfg_wr_data,
    input  logic [mexp_pkg::BASE_WIDTH-1:0]       s_base_value,
    input  logic [mexp_pkg::EXPONENT_WIDTH-1:0]   s_exponent,
    input  mexp_pkg::mexp_cmd_t                   cmd,
    output mexp_pkg::mexp_sts_t                   sts,
    input  logic                                  m_ready,
    output logic                                  m_valid,
    output logic [mexp_pkg::POWER_WIDTH-1:0]      m_power_mod
);

    localparam int EXP_USE = (EXP_BITS < mexp_pkg::EXPONENT_WIDTH) ?
                             EXP_BITS : mexp_pkg::EXPONENT_WIDTH;
    localparam int AW      = mexp_pkg::BASE_WIDTH;
    localparam int CW      = mexp_pkg::CNT_WIDTH;

    logic [MOD_BITS-1:0]             modulus_reg;
    logic [MOD_BITS-1:0]             acc_reg;
    logic [MOD_BITS-1:0]             base_reg;
    logic [EXP_USE-1:0]              exp_reg;
    logic [AW-1:0]                   ma_reg;
    logic [MOD_BITS-1:0]             mb_reg;
    logic [MOD_BITS-1:0]             r_reg;
    logic [CW-1:0]                   cnt_reg;
    logic                            busy_reg;
    logic                            done_reg;
    mexp_pkg::mul_op_t               op_reg;
    logic                            m_valid_reg;
    logic [mexp_pkg::POWER_WIDTH-1:0] power_reg;

    logic [MOD_BITS:0]   dbl;
    logic [MOD_BITS:0]   mod_ext;
    logic [MOD_BITS-1:0] red1;
    logic [MOD_BITS-1:0] addend;
    logic [MOD_BITS:0]   sum;
    logic [MOD_BITS-1:0] r_next;
    logic                last_step;

    // modulus register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg <= mexp_pkg::MODULUS_RESET[MOD_BITS-1:0];
        end else if (cfg_wr_en) begin
            modulus_reg <= cfg_wr_data[MOD_BITS-1:0];
        end
    end

    // one multiplier step: r = (2r + a_bit * b) mod m, with r, b below m
    always_comb begin
        mod_ext = {1'b0, modulus_reg};
        dbl     = {r_reg, 1'b0};
        red1    = (dbl >= mod_ext) ? MOD_BITS'(dbl - mod_ext) : dbl[MOD_BITS-1:0];
        addend  = ma_reg[AW-1] ? mb_reg : '0;
        sum     = {1'b0, red1} + {1'b0, addend};
        r_next  = (sum >= mod_ext) ? MOD_BITS'(sum - mod_ext) : sum[MOD_BITS-1:0];
    end

    assign last_step = busy_reg && (cnt_reg == '0);

    // multiplier control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= last_step;
            if (cmd.mul_start) begin
                busy_reg <= 1'b1;
            end else if (last_step) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // operand, accumulator and exponent registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ma_reg  <= s_base_value;
            acc_reg <= MOD_BITS'(1);
            exp_reg <= s_exponent[EXP_USE-1:0];
        end else if (cmd.mul_start) begin
            op_reg  <= cmd.mul_op;
            r_reg   <= '0;
            cnt_reg <= CW'(mexp_pkg::MUL_STEPS - 1);
            case (cmd.mul_op)
                mexp_pkg::MUL_ACC: begin
                    ma_reg <= AW'(acc_reg);
                    mb_reg <= base_reg;
                end
                mexp_pkg::MUL_SQR: begin
                    ma_reg <= AW'(base_reg);
                    mb_reg <= base_reg;
                end
                default: begin
                    // raw base already sits in the first operand
                    mb_reg <= MOD_BITS'(1);
                end
            endcase
        end else if (busy_reg) begin
            r_reg   <= r_next;
            ma_reg  <= {ma_reg[AW-2:0], 1'b0};
            cnt_reg <= cnt_reg - CW'(1);
            if (last_step) begin
                case (op_reg)
                    mexp_pkg::MUL_ACC: acc_reg  <= r_next;
                    default:           base_reg <= r_next;
                endcase
            end
        end
        if (cmd.exp_shift) begin
            exp_reg <= exp_reg >> 1;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            power_reg <= sts.mod_small ? '0 : mexp_pkg::POWER_WIDTH'(acc_reg);
        end
    end

    // status to the controller
    always_comb begin
        sts.mod_small = (modulus_reg < MOD_BITS'(2));
        sts.exp_zero  = (exp_reg == '0);
        sts.exp_lsb   = exp_reg[0];
        sts.exp_last  = ((exp_reg >> 1) == '0);
        sts.mul_done  = done_reg;
        sts.out_busy  = m_valid_reg && !m_ready;
    end

    assign m_valid     = m_valid_reg;
    assign m_power_mod = power_reg;

endmodule

// ===== design/modular_exponentiation_top.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation_top
// base_value ^ exponent mod modulus by right-to-left square-and-multiply on a
// shared bit-serial modular multiplier.
//
//   channel   direction  handshake          payload
//   s_        in         s_valid/s_ready    s_base_value, s_exponent
//   m_        out        m_valid/m_ready    m_power_mod
//   cfg_      in         cfg_wr_en          cfg_wr_data (modulus)
//
// A modular product is a launch plus 31 shift-add steps. Each clear exponent
// bit below the top set bit costs a square, each set bit a multiply and then
// a square, but the last set bit skips its square. Base reduction is the first
// product after an item is accepted. Zero exponent or modulus below two: no
// product runs and the result is loaded directly.
// One item at a time; a result held by low m_ready delays the next load.
// ----------------------------------------------------------------------------
module modular_exponentiation_top #(
    parameter int EXP_BITS = 32,
    parameter int MOD_BITS = 31
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [mexp_pkg::MODULUS_WIDTH-1:0]    cfg_wr_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [mexp_pkg::BASE_WIDTH-1:0]       s_base_value,
    input  logic [mexp_pkg::EXPONENT_WIDTH-1:0]   s_exponent,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [mexp_pkg::POWER_WIDTH-1:0]      m_power_mod
);

    mexp_pkg::mexp_cmd_t cmd;
    mexp_pkg::mexp_sts_t sts;

    // sequencer
    mexp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // operands, multiplier and output register
    mexp_datapath #(
        .EXP_BITS (EXP_BITS),
        .MOD_BITS (MOD_BITS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_base_value (s_base_value),
        .s_exponent   (s_exponent),
        .cmd          (cmd),
        .sts          (sts),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_power_mod  (m_power_mod)
    );

endmodule

// ===== design/mexp_checker.sv =====
// ----------------------------------------------------------------------------
// mexp_checker
// Port-level checks on the modular exponentiation block, bound to the top.
// ----------------------------------------------------------------------------
module mexp_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                cfg_wr_en,
    input logic [mexp_pkg::MODULUS_WIDTH-1:0]  cfg_wr_data,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic [mexp_pkg::BASE_WIDTH-1:0]     s_base_value,
    input logic [mexp_pkg::EXPONENT_WIDTH-1:0] s_exponent,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [mexp_pkg::POWER_WIDTH-1:0]    m_power_mod
);

    // a waiting result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_power_mod))
        else $error("result changed while stalled");

    // one item at a time: no acceptance right after an accepted item
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item accepted while busy");

    // a new result only comes from an item in flight
    a_result_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result without item in flight");

    // item in flight for at least the setup cycles
    a_min_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> ##1 !s_ready)
        else $error("item finished too early");

endmodule

bind modular_exponentiation_top mexp_checker u_mexp_checker (.*);

// ===== tb/sv/modular_exponentiation_top_tb.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation_top_tb
// Self-checking bench for the modular exponentiation block. A queue-fed driver
// sends base/exponent items and an in-bench square-and-multiply model predicts
// each power. A monitor compares every result in order. The modulus is
// reprogrammed between drained phases, including the extremes and the
// degenerate values below two.
// ----------------------------------------------------------------------------
module modular_exponentiation_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [mexp_pkg::BASE_WIDTH-1:0]     base_t;
    typedef logic [mexp_pkg::EXPONENT_WIDTH-1:0] exp_t;
    typedef logic [mexp_pkg::MODULUS_WIDTH-1:0]  mod_t;
    typedef logic [mexp_pkg::POWER_WIDTH-1:0]    power_t;

    localparam int   EXP_BITS    = 32;
    localparam int   MOD_BITS    = 31;
    localparam int   CYCLE_LIMIT = 3_500_000;
    localparam int   MAX_REPORTS = 10;
    localparam mod_t MODULUS_MAX = '1;

    typedef struct packed {
        base_t base_value;
        exp_t  exponent;
    } mexp_item_t;

    // dut ports, inputs known from time zero
    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    mod_t                      cfg_wr_data = '0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    base_t                     s_base_value = '0;
    exp_t                      s_exponent = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    power_t                    m_power_mod;

    // bench state
    mexp_item_t                items_pending[$];
    power_t                    powers_expected[$];
    mod_t                      modulus_model = mexp_pkg::MODULUS_RESET;
    bit                        idle_enabled = 1'b1;
    int                        send_gap = 0;
    int                        recv_stall = 0;
    int                        mismatch_count = 0;
    int                        cycle_count = 0;
    mexp_item_t                head_item;

    modular_exponentiation_top #(
        .EXP_BITS (EXP_BITS),
        .MOD_BITS (MOD_BITS)
    ) uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_base_value (s_base_value),
        .s_exponent   (s_exponent),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_power_mod  (m_power_mod)
    );

    // clock
    initial begin
        forever #2 aclk = ~aclk;
    end

    // right-to-left square-and-multiply, reduced after every product
    function automatic power_t predict_power(
        input base_t base_in,
        input exp_t  exp_in,
        input mod_t  mod_in
    );
        longint unsigned modv;
        longint unsigned acc;
        longint unsigned sq;
        modv = 64'(mod_in);
        if (modv < 64'd2) begin
            return '0;
        end
        acc = 64'd1;
        sq  = 64'(base_in) % modv;
        for (int i = 0; i < EXP_BITS; i++) begin
            if (exp_in[i]) begin
                acc = (acc * sq) % modv;
            end
            sq = (sq * sq) % modv;
        end
        return acc[mexp_pkg::POWER_WIDTH-1:0];
    endfunction

    task automatic push_item(input base_t b, input exp_t e);
        mexp_item_t it;
        it.base_value = b;
        it.exponent   = e;
        items_pending.push_back(it);
    endtask

    // random items biased toward edge bases and exponents
    task automatic queue_random_items(input int count);
        base_t b;
        exp_t  e;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 9))
                0: b = '0;
                1: b = base_t'(1);
                2: b = '1;
                3: b = modulus_model - 1'b1;
                4: b = modulus_model;
                default: b = base_t'($urandom());
            endcase
            case ($urandom_range(0, 7))
                0: e = '0;
                1: e = exp_t'($urandom_range(1, 16));
                2: e = '1;
                default: e = exp_t'($urandom());
            endcase
            push_item(b, e);
        end
    endtask

    // sender holds off until every expected result has come back
    task automatic wait_drained();
        @(negedge aclk);
        while (items_pending.size() != 0 || s_valid || powers_expected.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    // modulus write, only while the block is idle
    task automatic write_modulus(input mod_t value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        @(negedge aclk);
        modulus_model = value;
    endtask

    task automatic run_phase(input mod_t value, input int count);
        wait_drained();
        write_modulus(value);
        queue_random_items(count);
    endtask

    // stimulus sequence
    initial begin
        // directed items under the reset modulus
        push_item('0, '0);
        push_item('1, '0);
        push_item('0, 32'd1);
        push_item('0, '1);
        push_item(31'd1, '1);
        push_item('1, 32'd1);
        push_item('1, '1);
        push_item(31'd2, 32'd30);
        push_item(31'd2, 32'h8000_0000);
        push_item(31'd1000000006, 32'd2);
        push_item(31'd1000000007, 32'd5);
        push_item(31'd1000000008, 32'd3);
        push_item(31'd3, 32'hAAAA_AAAA);
        push_item(31'd7, 32'h5555_5555);
        push_item(31'h5555_5555, 32'hFFFF_FFFE);
        push_item(31'h2AAA_AAAA, 32'h0000_FFFF);
        push_item(31'd12345, 32'hFFFF_0000);
        push_item(31'd999999999, 32'd1000000005);
        push_item(31'd10, 32'd9);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // modulus extremes, degenerate values and random settings
        run_phase(MODULUS_MAX, 40);
        run_phase(31'd2, 20);
        run_phase(31'd0, 10);
        run_phase(31'd1, 10);
        run_phase(31'd3, 20);
        run_phase(31'h4000_0000, 20);
        run_phase(mod_t'($urandom_range(2, 32'h7FFF_FFFF)), 30);
        run_phase(mod_t'($urandom_range(2, 32'h7FFF_FFFF)), 30);
        run_phase(mod_t'($urandom_range(2, 32'h7FFF_FFFF)), 30);
        run_phase(mod_t'($urandom_range(2, 1000)), 30);

        // closing phase without any idling
        wait_drained();
        idle_enabled = 1'b0;
        write_modulus(mexp_pkg::MODULUS_RESET);
        queue_random_items(30);

        wait_drained();
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0 && powers_expected.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // driver: records accepted items, then presents the next one
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                powers_expected.push_back(predict_power(s_base_value, s_exponent,
                                                        modulus_model));
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    s_valid <= 1'b0;
                    send_gap--;
                end else if (items_pending.size() > 0) begin
                    head_item = items_pending.pop_front();
                    s_valid      <= 1'b1;
                    s_base_value <= head_item.base_value;
                    s_exponent   <= head_item.exponent;
                    if (idle_enabled && $urandom_range(0, 3) == 0) begin
                        send_gap = $urandom_range(1, 8);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: stall bursts on m_ready and in-order result check
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            recv_stall = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (powers_expected.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("unexpected result: power_mod=%0d", m_power_mod);
                    end
                end else if (m_power_mod !== powers_expected[0]) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("power_mod mismatch: expected=%0d actual=%0d",
                                 powers_expected[0], m_power_mod);
                    end
                    void'(powers_expected.pop_front());
                end else begin
                    void'(powers_expected.pop_front());
                end
            end
            if (recv_stall > 0) begin
                m_ready <= 1'b0;
                recv_stall--;
            end else begin
                m_ready <= 1'b1;
                if (idle_enabled && $urandom_range(0, 5) == 0) begin
                    recv_stall = $urandom_range(1, 8);
                end
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule

// ===== filelist.f =====
design/mexp_pkg.sv
design/mexp_ctrl.sv
design/mexp_datapath.sv
design/modular_exponentiation_top.sv
design/mexp_checker.sv
tb/sv/modular_exponentiation_top_tb.sv
